[hdl/evsd_pkg.sv]
// ----------------------------------------------------------------------------
// evsd_pkg
// Shared widths, register map, reset values and stage types for the encoder
// velocity and stall detect block.
// ----------------------------------------------------------------------------
package evsd_pkg;

	// field and register widths
	localparam int COUNT_W   = 16;
	localparam int COUNT_BITS = 16;
	localparam int GAIN_W    = 16;
	localparam int THR_W     = 32;
	localparam int LIMIT_W   = 8;
	localparam int MAG_W     = 32;
	localparam int VEL_W     = MAG_W + 1;
	localparam int PROD_W    = (COUNT_BITS + GAIN_W > MAG_W) ? COUNT_BITS + GAIN_W : MAG_W;

	// APB map
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [1:0] REG_GAIN      = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_LIMIT     = 2'd2;

	localparam logic [GAIN_W-1:0]  GAIN_RST      = GAIN_W'(256);
	localparam logic [THR_W-1:0]   THRESHOLD_RST = THR_W'(26);
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(15);

	// largest Q24.8 product magnitude; a larger product clamps here
	localparam logic [MAG_W-1:0] VEL_MAG_MAX = 32'hFFFE_0001;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain;
		logic [THR_W-1:0]   threshold;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] diff;
		logic                  down;
	} diff_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             down;
	} mag_t;

endpackage

[hdl/encoder_velocity_stall_detect_core.sv]
// ----------------------------------------------------------------------------
// encoder_velocity_stall_detect_core
// Encoder velocity in signed Q25.8 from periodic counter samples, with stall flag.
// ----------------------------------------------------------------------------
// Each input request carries one counter sample (count, counting_down). The
// block returns one result request per sample: the signed Q25.8 velocity
// (difference times gain, positive when counting down) and the sticky
// stalled flag after that sample.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. The user must write gain, threshold and stall limit through the APB
// port only while no sample is in flight (not enforced); pready is always high.
// The path is three registers deep (difference, multiply/clamp, sign and run
// update); a taken sample passes through them in that order to the output.
// One sample is taken per cycle while in_stall is low; the single 16x16
// multiply in the middle stage sets the cycle time.
// When out_stall is high the result register holds, and stages fill up
// behind it; in_stall rises only once all three stages are occupied.
// Reset clears the previous count, the run counter and the stall flag, and
// loads the register defaults (gain 256, threshold 26, limit 15).
// ----------------------------------------------------------------------------
module encoder_velocity_stall_detect_core import evsd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COUNT_W-1:0]      count,
	input  logic                    counting_down,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VEL_W-1:0] velocity,
	output logic                    stalled
);

	cfg_t  cfg;
	logic  s1_valid;
	logic  s1_stall;
	diff_t s1_data;
	logic  s2_valid;
	logic  s2_stall;
	mag_t  s2_data;

	evsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	evsd_diff u_diff (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (in_valid),
		.up_stall      (in_stall),
		.count         (count),
		.counting_down (counting_down),
		.dn_valid      (s1_valid),
		.dn_stall      (s1_stall),
		.dn_data       (s1_data)
	);

	evsd_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (s1_valid),
		.up_stall (s1_stall),
		.up_data  (s1_data),
		.dn_valid (s2_valid),
		.dn_stall (s2_stall),
		.dn_data  (s2_data)
	);

	evsd_stall u_stall (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (s2_valid),
		.up_stall (s2_stall),
		.up_data  (s2_data),
		.dn_valid (out_valid),
		.dn_stall (out_stall),
		.velocity (velocity),
		.stalled  (stalled)
	);

endmodule

[hdl/evsd_regs.sv]
// ----------------------------------------------------------------------------
// evsd_regs
// APB register file: velocity gain, low speed threshold, stall limit.
// ----------------------------------------------------------------------------
module evsd_regs import evsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [GAIN_W-1:0]  gain_q;
	logic [THR_W-1:0]   threshold_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RST;
			threshold_q <= THRESHOLD_RST;
			limit_q     <= LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GAIN:      gain_q      <= pwdata[GAIN_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				REG_LIMIT:     limit_q     <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN:      prdata = DATA_W'(gain_q);
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_LIMIT:     prdata = DATA_W'(limit_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.gain      = gain_q;
	assign cfg.threshold = threshold_q;
	assign cfg.limit     = limit_q;

endmodule

[hdl/evsd_diff.sv]
// ----------------------------------------------------------------------------
// evsd_diff
// First stage: keeps the previous count and forms the tick difference modulo
// the counter width in the direction of counting.
// ----------------------------------------------------------------------------
module evsd_diff import evsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  logic [COUNT_W-1:0] count,
	input  logic               counting_down,
	output logic               dn_valid,
	input  logic               dn_stall,
	output diff_t              dn_data
);

	logic                  valid_s1;
	diff_t                 data_s1;
	logic [COUNT_BITS-1:0] prev_q;
	logic [COUNT_BITS-1:0] cur;
	logic                  load;

	assign cur      = COUNT_BITS'(count);
	assign up_stall = valid_s1 && dn_stall;
	assign load     = up_valid && !up_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q   <= '0;
		end else begin
			if (!up_stall)
				valid_s1 <= up_valid;
			if (load)
				prev_q <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1.down <= counting_down;
			data_s1.diff <= counting_down ? (prev_q - cur) : (cur - prev_q);
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

[hdl/evsd_scale.sv]
// ----------------------------------------------------------------------------
// evsd_scale
// Second stage: multiplies the tick difference by the Q8.8 gain and clamps
// the magnitude.
// ----------------------------------------------------------------------------
module evsd_scale import evsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  up_valid,
	output logic  up_stall,
	input  diff_t up_data,
	output logic  dn_valid,
	input  logic  dn_stall,
	output mag_t  dn_data
);

	logic              valid_s2;
	mag_t              data_s2;
	logic [PROD_W-1:0] prod;
	logic [MAG_W-1:0]  mag;
	logic              load;

	assign up_stall = valid_s2 && dn_stall;
	assign load     = up_valid && !up_stall;

	assign prod = PROD_W'(up_data.diff) * PROD_W'(cfg.gain);
	assign mag  = (prod > PROD_W'(VEL_MAG_MAX)) ? VEL_MAG_MAX : prod[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!up_stall)
			valid_s2 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2.mag  <= mag;
			data_s2.down <= up_data.down;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

[hdl/evsd_stall.sv]
// ----------------------------------------------------------------------------
// evsd_stall
// Output stage: applies the sign, counts the low speed run and holds the
// sticky stall flag. Its result register drives the output channel.
// ----------------------------------------------------------------------------
module evsd_stall import evsd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    up_valid,
	output logic                    up_stall,
	input  mag_t                    up_data,
	output logic                    dn_valid,
	input  logic                    dn_stall,
	output logic signed [VEL_W-1:0] velocity,
	output logic                    stalled
);

	logic                    valid_s3;
	logic signed [VEL_W-1:0] velocity_s3;
	logic                    stalled_s3;
	logic [LIMIT_W-1:0]      run_q;
	logic                    flag_q;
	logic [LIMIT_W-1:0]      run_inc;
	logic                    low;
	logic                    hit;
	logic [VEL_W-1:0]        mag_ext;
	logic                    load;

	assign up_stall = valid_s3 && dn_stall;
	assign load     = up_valid && !up_stall;

	assign low     = up_data.mag < cfg.threshold;
	assign run_inc = run_q + LIMIT_W'(1);
	assign hit     = low && (run_inc == cfg.limit);
	assign mag_ext = VEL_W'(up_data.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			run_q    <= '0;
			flag_q   <= 1'b0;
		end else begin
			if (!up_stall)
				valid_s3 <= up_valid;
			if (load) begin
				// restart the run on a stall or on any fast sample
				if (hit || !low)
					run_q <= '0;
				else
					run_q <= run_inc;
				if (hit)
					flag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			velocity_s3 <= up_data.down ? signed'(mag_ext) : signed'(-mag_ext);
			stalled_s3  <= flag_q || hit;
		end
	end

	assign dn_valid = valid_s3;
	assign velocity = velocity_s3;
	assign stalled  = stalled_s3;

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |=> flag_q)
		else $error("stall flag cleared without reset");

	a_out_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (stalled_s3 == flag_q))
		else $error("reported stall disagrees with stall flag");

	a_fast_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !low) |=> (run_q == '0))
		else $error("low speed run kept after a fast sample");

	a_hit_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load && hit) |=> (flag_q && run_q == '0))
		else $error("stall not declared at limit");

endmodule

[bench/tb_encoder_velocity_stall_detect_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_velocity_stall_detect_core
// Self-checking bench for the encoder velocity and stall detect core.
// ----------------------------------------------------------------------------
// Counter samples go in through the valid/stall input channel; a local copy of
// the velocity arithmetic and the low-speed run counter predicts each result,
// which is then compared field by field as it leaves the output channel.
// Directed tests hit counter wrap, the first sample, gain and count extremes,
// a zero threshold, an unmapped register and a stall limit that is lowered
// below a running count. Random phases then drive encoder-like motion under
// changing gain, threshold and limit settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_encoder_velocity_stall_detect_core;
	import evsd_pkg::*;

	localparam int            WATCHDOG_LIMIT = 1000;
	localparam int            PIPE_SETTLE    = 8;
	localparam int            RANDOM_SAMPLES = 1350;
	localparam logic [1:0]    REG_UNMAPPED   = 2'd3;

	typedef struct {
		logic [VEL_W-1:0] velocity;
		logic             stalled;
	} velocity_result_t;

	logic                    clk;
	logic                    arst_n        = 1'b0;
	logic                    psel          = 1'b0;
	logic                    penable       = 1'b0;
	logic                    pwrite        = 1'b0;
	logic [ADDR_W-1:0]       paddr         = '0;
	logic [DATA_W-1:0]       pwdata        = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid      = 1'b0;
	logic                    in_stall;
	logic [COUNT_W-1:0]      count         = '0;
	logic                    counting_down = 1'b0;
	logic                    out_valid;
	logic                    out_stall     = 1'b0;
	logic signed [VEL_W-1:0] velocity;
	logic                    stalled;

	// predictor copy of the block's registers and state
	logic [GAIN_W-1:0]  cfg_gain      = GAIN_RST;
	logic [THR_W-1:0]   cfg_threshold = THRESHOLD_RST;
	logic [LIMIT_W-1:0] cfg_limit     = LIMIT_RST;
	logic [COUNT_W-1:0] prev_sample   = '0;
	logic [LIMIT_W-1:0] low_run       = '0;
	logic               stall_seen    = 1'b0;

	velocity_result_t velocity_expect_q[$];

	int unsigned samples_sent    = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes      = 0;
	int unsigned mismatch_count  = 0;
	bit          idle_off        = 1'b0;

	encoder_velocity_stall_detect_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.count         (count),
		.counting_down (counting_down),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.velocity      (velocity),
		.stalled       (stalled)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic void predict_velocity(input logic [COUNT_W-1:0] sample,
			input logic down);
		logic [COUNT_W-1:0] ticks;
		logic [63:0]        magnitude;
		logic [VEL_W-1:0]   mag_bits;
		velocity_result_t   res;
		ticks = down ? prev_sample - sample : sample - prev_sample;
		magnitude = 64'(ticks) * 64'(cfg_gain);
		if (magnitude > 64'(VEL_MAG_MAX)) begin
			magnitude = 64'(VEL_MAG_MAX);
		end
		mag_bits = magnitude[VEL_W-1:0];
		res.velocity = down ? mag_bits : -mag_bits;
		prev_sample = sample;
		if (magnitude < 64'(cfg_threshold)) begin
			low_run = low_run + 1'b1;
			if (low_run == cfg_limit) begin
				stall_seen = 1'b1;
				low_run = '0;
			end
		end else begin
			low_run = '0;
		end
		res.stalled = stall_seen;
		velocity_expect_q.push_back(res);
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		$display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin : result_check
		velocity_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (velocity_expect_q.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, 64'(velocity));
			end else begin
				want = velocity_expect_q.pop_front();
				results_checked++;
				if (velocity !== want.velocity) begin
					report_mismatch("velocity", 64'(want.velocity), 64'(velocity));
				end
				if (stalled !== want.stalled) begin
					report_mismatch("stalled", 64'(want.stalled), 64'(stalled));
				end
			end
		end
	end

	// receiver: after each taken result, may hold stall before the next; never while idle_off
	int unsigned hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				hold_left = idle_off ? 0 : $urandom_range(0, 4);
			end else if (hold_left > 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic send_sample(input logic [COUNT_W-1:0] sample, input logic down);
		int unsigned gap;
		gap = idle_off ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		count         <= sample;
		counting_down <= down;
		do begin
			@(posedge clk);
		end while (!(in_valid && !in_stall));
		predict_velocity(sample, down);
		samples_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (velocity_expect_q.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// call only with the pipeline drained
	task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		apb_write({idx, 2'b00}, data);
		reg_writes++;
		case (idx)
			REG_GAIN:      cfg_gain      = data[GAIN_W-1:0];
			REG_THRESHOLD: cfg_threshold = data[THR_W-1:0];
			REG_LIMIT:     cfg_limit     = data[LIMIT_W-1:0];
			default:       ;
		endcase
	endtask

	task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [THR_W-1:0] thr,
			input logic [LIMIT_W-1:0] limit);
		drain_results();
		write_register(REG_GAIN, DATA_W'(gain));
		write_register(REG_THRESHOLD, DATA_W'(thr));
		write_register(REG_LIMIT, DATA_W'(limit));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_extremes();
		// reset config; first sample compares against zero
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b1);
		// full-scale gain: largest magnitude in both directions
		drain_results();
		write_register(REG_GAIN, DATA_W'(16'hFFFF));
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		drain_results();
		write_register(REG_GAIN, '0);
		send_sample(16'h1234, 1'b1);
	endtask

	task automatic test_zero_threshold();
		// nothing counts as low, so the run stays clear
		set_config('0, '0, 8'd1);
		send_sample(16'h1234, 1'b0);
		send_sample(16'h1234, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b1);
		// unmapped register must leave the map untouched
		drain_results();
		write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h00F0, 1'b1);
	endtask

	task automatic test_limit_wrap();
		int unsigned k;
		// build a run of 10, then drop the limit to zero: stall only after wrap
		set_config(16'($urandom), 32'hFFFF_FFFF, 8'd200);
		for (k = 0; k < 10; k++) begin
			send_sample(16'($urandom), 1'($urandom));
		end
		drain_results();
		write_register(REG_LIMIT, '0);
		for (k = 0; k < 250; k++) begin
			send_sample(16'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_random_motion();
		int unsigned        phase_len;
		int unsigned        k;
		int unsigned        pick;
		logic [GAIN_W-1:0]  gain;
		logic [THR_W-1:0]   thr;
		logic [LIMIT_W-1:0] limit;
		logic [COUNT_W-1:0] position;
		logic [COUNT_W-1:0] step;
		logic               dir;
		int unsigned        sent;
		position = prev_sample;
		dir = 1'b0;
		sent = 0;
		while (sent < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 3))
				0:       gain = '0;
				1:       gain = '1;
				2:       gain = GAIN_RST;
				default: gain = 16'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0:       thr = '0;
				1:       thr = '1;
				2:       thr = $urandom_range(0, 4096);
				default: thr = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       limit = '0;
				1:       limit = 8'd1;
				2:       limit = 8'd255;
				default: limit = 8'($urandom_range(1, 254));
			endcase
			set_config(gain, thr, limit);
			idle_off = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(60, 180);
			for (k = 0; k < phase_len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					step = 16'($urandom_range(0, 8));
				end else if (pick < 75) begin
					step = '0;
				end else if (pick < 85) begin
					step = 16'($urandom_range(0, 16'h3FF));
				end else if (pick < 92) begin
					dir = ~dir;
					step = 16'($urandom_range(0, 8));
				end else begin
					// noise: jump anywhere, direction unrelated to motion
					step = 16'($urandom);
					dir = 1'($urandom);
				end
				position = dir ? position - step : position + step;
				send_sample(position, dir);
			end
			sent += phase_len;
		end
		idle_off = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_zero_threshold();
		test_limit_wrap();
		test_random_motion();
		drain_results();
		$display("covered %0d samples and %0d checked results across %0d register writes",
			samples_sent, results_checked, reg_writes);
		$display("stall flag raised during run: %0s, mismatches: %0d",
			stall_seen ? "yes" : "no", mismatch_count);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[encoder_velocity_stall_detect_core.f]
hdl/evsd_pkg.sv
hdl/evsd_regs.sv
hdl/evsd_diff.sv
hdl/evsd_scale.sv
hdl/evsd_stall.sv
hdl/encoder_velocity_stall_detect_core.sv
bench/tb_encoder_velocity_stall_detect_core.sv
